FILE: rtl/tilemap_blob_autotile_assert.svh
// assertion macros for the tilemap blob autotile block
`ifndef TILEMAP_BLOB_AUTOTILE_ASSERT_SVH
`define TILEMAP_BLOB_AUTOTILE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define TBA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define TBA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

FILE: rtl/tba_pkg.sv
// types, shape table and control program of the tilemap blob autotile block
package tba_pkg;

	localparam int COORD_W = 5;
	localparam int CODE_W = 8;
	localparam int SHAPE_W = 6;
	localparam int SHAPE_COUNT = 47;
	localparam int STEP_W = 5;

	typedef struct packed {
		logic [1:0]         operation;
		logic [3:0]         map_select;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [1:0]         layer;
		logic [CODE_W-1:0]  tile_value;
	} item_t;

	typedef struct packed {
		logic [3:0]         out_map;
		logic [COORD_W-1:0] out_col;
		logic [COORD_W-1:0] out_row;
		logic [1:0]         out_layer;
		logic [SHAPE_W-1:0] shape_index;
		logic               last;
	} result_t;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_PLACE = 2'd1;
	localparam logic [1:0] OP_CLASSIFY = 2'd2;

	// neighbour masks, first fit wins
	localparam logic [CODE_W-1:0] SHAPE_TABLE [SHAPE_COUNT] = '{
		8'hFF, 8'h7F, 8'hDF, 8'h5F, 8'h1F,
		8'hF7, 8'h77, 8'hD7, 8'h57, 8'h17, 8'hC7, 8'h47, 8'h07,
		8'hFD, 8'h7D, 8'hDD, 8'h5D, 8'h1D, 8'hF5, 8'h75, 8'hD5, 8'h55, 8'h15,
		8'hC5, 8'h45, 8'h05, 8'hF1, 8'h71, 8'hD1, 8'h51, 8'h11, 8'hC1, 8'h41, 8'h01,
		8'h7C, 8'h5C, 8'h1C, 8'h74, 8'h54, 8'h14, 8'h44, 8'h04,
		8'h70, 8'h50, 8'h10, 8'h40, 8'h00
	};

	typedef enum logic [3:0] {
		A_NOP,
		A_PLANE,
		A_WRITE,
		A_LOAD,
		A_ROT_L,
		A_ROT_L3U,
		A_ROT_LU,
		A_CLASSIFY,
		A_FLUSH
	} act_t;

	typedef enum logic [2:0] {
		S_NEXT,
		S_LOOP,
		S_BR_CLASSIFY,
		S_END_WRITE,
		S_JUMP,
		S_END
	} seq_t;

	typedef struct packed {
		act_t              act;
		seq_t              seq;
		logic [STEP_W-1:0] target;
	} ucode_t;

	localparam logic [STEP_W-1:0] STEP_LOAD = 5'd2;
	localparam logic [STEP_W-1:0] STEP_FLUSH = 5'd21;
	localparam logic [STEP_W-1:0] STEP_SINGLE = 5'd22;

	function automatic logic [SHAPE_W-1:0] shape_index(input logic [CODE_W-1:0] mask);
		logic [SHAPE_W-1:0] idx;
		logic               hit;
		idx = '0;
		hit = 1'b0;
		for (int k = 0; k < SHAPE_COUNT; k++) begin
			if (!hit && ((SHAPE_TABLE[k] & mask) == SHAPE_TABLE[k])) begin
				idx = SHAPE_W'(k + 1);
				hit = 1'b1;
			end
		end
		return idx;
	endfunction

	// control program: setup, write, window fill, walk over the 3x3 centres or the single centre, flush
	function automatic ucode_t ucode_word(input logic [STEP_W-1:0] step);
		ucode_t uc;
		case (step)
			5'd0: uc = '{A_PLANE, S_BR_CLASSIFY, STEP_LOAD};
			5'd1: uc = '{A_WRITE, S_END_WRITE, '0};
			5'd2: uc = '{A_LOAD, S_LOOP, '0};
			5'd3: uc = '{A_NOP, S_BR_CLASSIFY, STEP_SINGLE};
			5'd4, 5'd6, 5'd8, 5'd10, 5'd12, 5'd14, 5'd16, 5'd18, 5'd20:
				uc = '{A_CLASSIFY, S_NEXT, '0};
			5'd5, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19:
				uc = '{A_ROT_L, S_NEXT, '0};
			5'd9, 5'd15: uc = '{A_ROT_L3U, S_NEXT, '0};
			5'd21: uc = '{A_FLUSH, S_END, '0};
			5'd22: uc = '{A_ROT_LU, S_NEXT, '0};
			5'd23: uc = '{A_CLASSIFY, S_JUMP, STEP_FLUSH};
			default: uc = '{A_NOP, S_END, '0};
		endcase
		return uc;
	endfunction

endpackage

FILE: rtl/tilemap_blob_autotile.sv
// top level of the tilemap blob autotile block: tile store, window and control sequencer
//
// An item is taken on a rising edge with start high and busy low. Write stores a
// code, place stores a code and reclassifies the 3x3 neighbourhood, classify
// handles one cell. Items with operation 3 or an address outside the grid, maps
// or layers are taken and dropped at once.
// Each result is shown on result for one cycle with result_strobe high; the
// receiver takes every one and cannot stall the block. result.last marks the
// final result of an item. Results of an item come out while it runs, the final
// one in the first cycle with busy low. One item is worked on at a time. The
// single memory port sets the length of a run: the 5x5 window round the cell
// is read one code per cycle. After reset the store is swept to zero one entry
// per cycle, with busy high, over all MAP_COUNT*LAYER_COUNT*GRID_SIZE*GRID_SIZE
// entries (36864 by default).
module tilemap_blob_autotile #(
	parameter int GRID_SIZE = 32,
	parameter int LAYER_COUNT = 4,
	parameter int MAP_COUNT = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  tba_pkg::item_t   item,
	output logic             busy,
	output logic             result_strobe,
	output tba_pkg::result_t result
);

	`include "tilemap_blob_autotile_assert.svh"

	localparam int PLANES = MAP_COUNT * LAYER_COUNT;
	localparam int PLANE_W = (PLANES > 1) ? $clog2(PLANES) : 1;
	localparam int CELLS_PER_LAYER = GRID_SIZE * GRID_SIZE;
	localparam int DEPTH = PLANES * CELLS_PER_LAYER;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int WIN = 5;
	localparam int WIN_CELLS = WIN * WIN;
	localparam int SCAN_W = $clog2(WIN);
	localparam int CS_W = tba_pkg::COORD_W + 2;
	localparam int CODE_W = tba_pkg::CODE_W;

	localparam logic [ADDR_W-1:0] GRID_A = ADDR_W'(GRID_SIZE);
	localparam logic [ADDR_W-1:0] CPL_A = ADDR_W'(CELLS_PER_LAYER);
	localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(DEPTH - 1);
	localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(WIN - 1);
	localparam int NB_IDX [8] = '{
		0 * WIN + 0, 0 * WIN + 1, 0 * WIN + 2, 1 * WIN + 2,
		2 * WIN + 2, 2 * WIN + 1, 2 * WIN + 0, 1 * WIN + 0
	};
	localparam int CENTRE_IDX = 1 * WIN + 1;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_RUN   = 3'b100
	} state_t;

	typedef struct packed {
		logic              ok;
		logic [CODE_W-1:0] code;
	} wcell_t;

	state_t                        state_q;
	logic [tba_pkg::STEP_W-1:0]    step_q;
	logic [tba_pkg::STEP_W-1:0]    step_nxt;
	logic                          run_end;
	logic [ADDR_W-1:0]             clr_q;
	tba_pkg::ucode_t               uc;
	logic                          run;
	logic                          accept;
	logic                          item_ok;

	logic [1:0]                    op_q;
	logic [3:0]                    map_q;
	logic [tba_pkg::COORD_W-1:0]   col_q;
	logic [tba_pkg::COORD_W-1:0]   row_q;
	logic [1:0]                    layer_q;
	logic [CODE_W-1:0]             value_q;
	logic [PLANE_W-1:0]            plane_q;
	logic [ADDR_W-1:0]             plane_base_q;
	logic [SCAN_W-1:0]             sc_q;
	logic [SCAN_W-1:0]             sr_q;
	logic                          scan_done;
	logic signed [CS_W-1:0]        cell_x_q;
	logic signed [CS_W-1:0]        cell_y_q;

	logic signed [CS_W-1:0]        ax;
	logic signed [CS_W-1:0]        ay;
	logic                          in_grid;
	logic [ADDR_W-1:0]             mem_addr;
	logic                          mem_we;
	logic [CODE_W-1:0]             mem_wdata;
	logic [CODE_W-1:0]             mem [DEPTH];
	logic [CODE_W-1:0]             rdata_s1;
	logic                          ld_s1;
	logic                          rd_ok_s1;

	wcell_t                        win_q [WIN_CELLS];
	wcell_t                        centre;
	logic [CODE_W-1:0]             mask;
	logic                          produce;
	logic                          flush;
	logic                          emit;
	logic                          pend_vld_q;
	tba_pkg::result_t              pend_q;
	tba_pkg::result_t              res_q;
	logic                          strobe_q;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign run = (state_q == ST_RUN);
	assign uc = tba_pkg::ucode_word(step_q);

	assign item_ok = ((item.operation == tba_pkg::OP_WRITE) ||
			(item.operation == tba_pkg::OP_PLACE) ||
			(item.operation == tba_pkg::OP_CLASSIFY)) &&
		(int'(item.map_select) < MAP_COUNT) && (int'(item.layer) < LAYER_COUNT) &&
		(int'(item.col) < GRID_SIZE) && (int'(item.row) < GRID_SIZE);

	assign scan_done = (sc_q == SCAN_LAST) && (sr_q == SCAN_LAST);

	// sequencer
	always_comb begin
		step_nxt = step_q + tba_pkg::STEP_W'(1);
		run_end = 1'b0;
		case (uc.seq)
			tba_pkg::S_NEXT: ;
			tba_pkg::S_LOOP: if (!scan_done) step_nxt = step_q;
			tba_pkg::S_BR_CLASSIFY: if (op_q == tba_pkg::OP_CLASSIFY) step_nxt = uc.target;
			tba_pkg::S_END_WRITE: if (op_q == tba_pkg::OP_WRITE) run_end = 1'b1;
			tba_pkg::S_JUMP: step_nxt = uc.target;
			tba_pkg::S_END: run_end = 1'b1;
			default: run_end = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			step_q <= '0;
			clr_q <= '0;
			ld_s1 <= 1'b0;
		end else begin
			ld_s1 <= run && (uc.act == tba_pkg::A_LOAD);
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == LAST_A) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					step_q <= '0;
					if (accept && item_ok) state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (run_end) begin
						state_q <= ST_IDLE;
						step_q <= '0;
					end else begin
						step_q <= step_nxt;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item registers, address setup, scan and centre coordinates
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= item.operation;
			map_q <= item.map_select;
			col_q <= item.col;
			row_q <= item.row;
			layer_q <= item.layer;
			value_q <= item.tile_value;
			plane_q <= PLANE_W'(int'(item.map_select) * LAYER_COUNT + int'(item.layer));
		end
		if (run) begin
			case (uc.act)
				tba_pkg::A_PLANE: begin
					plane_base_q <= ADDR_W'(plane_q) * CPL_A;
					sc_q <= '0;
					sr_q <= '0;
					cell_x_q <= CS_W'(col_q) - CS_W'(1);
					cell_y_q <= CS_W'(row_q) - CS_W'(1);
				end
				tba_pkg::A_LOAD: begin
					if (sc_q == SCAN_LAST) begin
						sc_q <= '0;
						sr_q <= sr_q + SCAN_W'(1);
					end else begin
						sc_q <= sc_q + SCAN_W'(1);
					end
				end
				tba_pkg::A_ROT_L: cell_x_q <= cell_x_q + CS_W'(1);
				tba_pkg::A_ROT_L3U: begin
					cell_x_q <= cell_x_q - CS_W'(2);
					cell_y_q <= cell_y_q + CS_W'(1);
				end
				tba_pkg::A_ROT_LU: begin
					cell_x_q <= cell_x_q + CS_W'(1);
					cell_y_q <= cell_y_q + CS_W'(1);
				end
				default: ;
			endcase
		end
	end

	// store address: the clear sweep, the written cell, or the window cell being fetched
	always_comb begin
		if (uc.act == tba_pkg::A_WRITE) begin
			ax = CS_W'(col_q);
			ay = CS_W'(row_q);
		end else begin
			ax = CS_W'(col_q) + CS_W'(sc_q) - CS_W'(2);
			ay = CS_W'(row_q) + CS_W'(sr_q) - CS_W'(2);
		end
		in_grid = (ax >= 0) && (int'(ax) < GRID_SIZE) && (ay >= 0) && (int'(ay) < GRID_SIZE);
		mem_we = 1'b0;
		mem_wdata = value_q;
		mem_addr = plane_base_q + ADDR_W'($unsigned(ay)) * GRID_A + ADDR_W'($unsigned(ax));
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wdata = '0;
			mem_addr = clr_q;
		end else if (run && (uc.act == tba_pkg::A_WRITE)) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		rdata_s1 <= mem[mem_addr];
		rd_ok_s1 <= in_grid;
	end

	// window: raster fill from the store, then rotations bring each centre to (1,1)
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			for (int i = 0; i < WIN_CELLS - 1; i++) win_q[i] <= win_q[i + 1];
			win_q[WIN_CELLS - 1] <= '{ok: rd_ok_s1, code: rdata_s1};
		end else if (run) begin
			case (uc.act)
				tba_pkg::A_ROT_L:
					for (int r = 0; r < WIN; r++)
						for (int c = 0; c < WIN; c++)
							win_q[r * WIN + c] <= win_q[r * WIN + (c + 1) % WIN];
				tba_pkg::A_ROT_L3U:
					for (int r = 0; r < WIN; r++)
						for (int c = 0; c < WIN; c++)
							win_q[r * WIN + c] <= win_q[((r + 1) % WIN) * WIN + (c + 3) % WIN];
				tba_pkg::A_ROT_LU:
					for (int r = 0; r < WIN; r++)
						for (int c = 0; c < WIN; c++)
							win_q[r * WIN + c] <= win_q[((r + 1) % WIN) * WIN + (c + 1) % WIN];
				default: ;
			endcase
		end
	end

	// neighbour mask, bit 7 up-left round clockwise to bit 0 left
	always_comb begin
		centre = win_q[CENTRE_IDX];
		for (int k = 0; k < 8; k++)
			mask[7 - k] = win_q[NB_IDX[k]].ok && (win_q[NB_IDX[k]].code == centre.code);
	end

	// results are held back one step so the final one can carry last
	assign produce = run && (uc.act == tba_pkg::A_CLASSIFY) && centre.ok && (centre.code != '0);
	assign flush = run && (uc.act == tba_pkg::A_FLUSH);
	assign emit = (produce || flush) && pend_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
			if (produce) pend_vld_q <= 1'b1;
			else if (flush) pend_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= '{
				out_map: pend_q.out_map,
				out_col: pend_q.out_col,
				out_row: pend_q.out_row,
				out_layer: pend_q.out_layer,
				shape_index: pend_q.shape_index,
				last: flush
			};
		end
		if (produce) begin
			pend_q <= '{
				out_map: map_q,
				out_col: cell_x_q[tba_pkg::COORD_W-1:0],
				out_row: cell_y_q[tba_pkg::COORD_W-1:0],
				out_layer: layer_q,
				shape_index: tba_pkg::shape_index(mask),
				last: 1'b0
			};
		end
	end

	assign result_strobe = strobe_q;
	assign result = res_q;

	`TBA_ASSERT_IMP(a_idle_no_pending, state_q == ST_IDLE, !pend_vld_q, "result left pending at idle")
	`TBA_ASSERT_NXT(a_flush_clears, flush, !pend_vld_q, "pending result survived flush")
	`TBA_ASSERT_NXT(a_last_closes, result_strobe && result.last, !result_strobe, "result after last")
	`TBA_ASSERT_IMP(a_fill_in_run, ld_s1, state_q == ST_RUN, "window fill outside a run")

endmodule

FILE: tb/testbench.sv
// testbench for the tilemap blob autotile block: directed table, random bursts, mirror store
`timescale 1ns / 1ps

module testbench;

	localparam int GRID_N = 32;
	localparam int LAYERS_N = 4;
	localparam int MAPS_N = 9;
	localparam int STORE_N = MAPS_N * LAYERS_N * GRID_N * GRID_N;
	localparam int RANDOM_ITEMS = 105;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 60;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [tba_pkg::SHAPE_W-1:0] SHAPE_FULL = 6'd1;
	localparam logic [tba_pkg::SHAPE_W-1:0] SHAPE_ALONE = 6'd47;
	localparam int EXPECT_PREDICTED = -1;

	// neighbour offsets, mask bit 7 first: up-left, up, up-right, right,
	// down-right, down, down-left, left
	localparam int NB_DX [8] = '{-1, 0, 1, 1, 1, 0, -1, -1};
	localparam int NB_DY [8] = '{-1, -1, -1, 0, 1, 1, 1, 0};

	typedef struct {
		tba_pkg::item_t   it;
		int               n_typed;
		tba_pkg::result_t typed;
	} stim_row_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	tba_pkg::item_t   item;
	logic             busy;
	logic             result_strobe;
	tba_pkg::result_t result;
	stim_row_t        cur_row;

	logic [tba_pkg::CODE_W-1:0] tile_mirror [STORE_N];
	tba_pkg::result_t           shapes_due [$];
	stim_row_t                  directed_rows [$];
	int                         errors = 0;
	int                         cycles = 0;

	// focus of the random traffic: a small patch of one layer
	int                         focus_map;
	int                         focus_layer;
	int                         focus_col;
	int                         focus_row;
	logic [tba_pkg::CODE_W-1:0] palette [2];

	tilemap_blob_autotile #(
		.GRID_SIZE(GRID_N),
		.LAYER_COUNT(LAYERS_N),
		.MAP_COUNT(MAPS_N)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.result_strobe(result_strobe),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
	endtask

	function automatic int cell_index(input int m, input int x, input int y, input int z);
		return ((m * LAYERS_N + z) * GRID_N + y) * GRID_N + x;
	endfunction

	function automatic bit on_grid(input int x, input int y);
		return x >= 0 && y >= 0 && x < GRID_N && y < GRID_N;
	endfunction

	function automatic void classify_cell(input int m, input int x, input int y, input int z,
			ref tba_pkg::result_t q[$]);
		logic [tba_pkg::CODE_W-1:0]  code;
		logic [tba_pkg::CODE_W-1:0]  mask;
		logic [tba_pkg::SHAPE_W-1:0] idx;
		int                          nx;
		int                          ny;
		code = tile_mirror[cell_index(m, x, y, z)];
		if (code == '0)
			return;
		mask = '0;
		for (int k = 0; k < 8; k++) begin
			nx = x + NB_DX[k];
			ny = y + NB_DY[k];
			if (on_grid(nx, ny) && tile_mirror[cell_index(m, nx, ny, z)] == code)
				mask[7-k] = 1'b1;
		end
		// walk backwards so the earliest fitting entry is the one kept
		idx = '0;
		for (int k = tba_pkg::SHAPE_COUNT - 1; k >= 0; k--) begin
			if ((tba_pkg::SHAPE_TABLE[k] & mask) == tba_pkg::SHAPE_TABLE[k])
				idx = tba_pkg::SHAPE_W'(k + 1);
		end
		q.push_back(tba_pkg::result_t'{4'(m), 5'(x), 5'(y), 2'(z), idx, 1'b0});
	endfunction

	function automatic void predict_item(input tba_pkg::item_t it, ref tba_pkg::result_t q[$]);
		int m;
		int x;
		int y;
		int z;
		m = int'(it.map_select);
		x = int'(it.col);
		y = int'(it.row);
		z = int'(it.layer);
		if (it.operation == OP_UNUSED || m >= MAPS_N || z >= LAYERS_N || !on_grid(x, y))
			return;
		case (it.operation)
			tba_pkg::OP_WRITE: tile_mirror[cell_index(m, x, y, z)] = it.tile_value;
			tba_pkg::OP_CLASSIFY: classify_cell(m, x, y, z, q);
			tba_pkg::OP_PLACE: begin
				tile_mirror[cell_index(m, x, y, z)] = it.tile_value;
				for (int dy = -1; dy <= 1; dy++)
					for (int dx = -1; dx <= 1; dx++)
						if (on_grid(x + dx, y + dy))
							classify_cell(m, x + dx, y + dy, z, q);
			end
			default: ;
		endcase
		if (q.size() > 0)
			q[q.size()-1].last = 1'b1;
	endfunction

	// result check first, then the new transaction's expectations
	always @(posedge clk) begin
		tba_pkg::result_t fresh_q [$];
		tba_pkg::result_t expd;
		if (arst_n) begin
			if (result_strobe) begin
				if (shapes_due.size() == 0) begin
					flag_mismatch("unexpected result", 32'(result), '0);
				end else begin
					expd = shapes_due.pop_front();
					if (result.out_map !== expd.out_map)
						flag_mismatch("out_map", 32'(result.out_map), 32'(expd.out_map));
					if (result.out_col !== expd.out_col)
						flag_mismatch("out_col", 32'(result.out_col), 32'(expd.out_col));
					if (result.out_row !== expd.out_row)
						flag_mismatch("out_row", 32'(result.out_row), 32'(expd.out_row));
					if (result.out_layer !== expd.out_layer)
						flag_mismatch("out_layer", 32'(result.out_layer),
							32'(expd.out_layer));
					if (result.shape_index !== expd.shape_index)
						flag_mismatch("shape_index", 32'(result.shape_index),
							32'(expd.shape_index));
					if (result.last !== expd.last)
						flag_mismatch("last", 32'(result.last), 32'(expd.last));
				end
			end
			if (start && !busy) begin
				fresh_q.delete();
				predict_item(item, fresh_q);
				if (cur_row.n_typed == EXPECT_PREDICTED) begin
					foreach (fresh_q[i])
						shapes_due.push_back(fresh_q[i]);
				end else if (cur_row.n_typed == 1) begin
					shapes_due.push_back(cur_row.typed);
				end
			end
		end
	end

	task automatic add_row(input logic [1:0] op, input logic [3:0] m, input logic [4:0] c,
			input logic [4:0] r, input logic [1:0] l, input logic [7:0] code,
			input int n_typed, input tba_pkg::result_t typed);
		stim_row_t row;
		row.it = tba_pkg::item_t'{op, m, c, r, l, code};
		row.n_typed = n_typed;
		row.typed = typed;
		directed_rows.push_back(row);
	endtask

	task automatic send_row(input stim_row_t row, input int idle);
		if (idle > 0) begin
			start <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		start <= 1'b1;
		item <= row.it;
		cur_row <= row;
		do @(posedge clk); while (busy);
	endtask

	function automatic int clamp_coord(input int v);
		return v < 0 ? 0 : (v >= GRID_N ? GRID_N - 1 : v);
	endfunction

	function automatic int pick_focus_coord();
		if ($urandom_range(0, 9) < 3)
			return $urandom_range(0, 1) ? GRID_N - 1 : 0;
		return $urandom_range(0, GRID_N - 1);
	endfunction

	task automatic new_focus();
		focus_map = $urandom_range(0, MAPS_N - 1);
		focus_layer = $urandom_range(0, LAYERS_N - 1);
		focus_col = pick_focus_coord();
		focus_row = pick_focus_coord();
		palette[0] = tba_pkg::CODE_W'($urandom_range(1, 255));
		palette[1] = tba_pkg::CODE_W'($urandom_range(1, 255));
	endtask

	function automatic tba_pkg::item_t random_item();
		tba_pkg::item_t it;
		int             roll;
		roll = $urandom_range(0, 99);
		if (roll < 35)
			it.operation = tba_pkg::OP_WRITE;
		else if (roll < 70)
			it.operation = tba_pkg::OP_PLACE;
		else if (roll < 93)
			it.operation = tba_pkg::OP_CLASSIFY;
		else
			it.operation = OP_UNUSED;
		if ($urandom_range(0, 99) < 5)
			it.map_select = 4'($urandom_range(MAPS_N, 15));
		else
			it.map_select = 4'(focus_map);
		it.col = 5'(clamp_coord(focus_col + $urandom_range(0, 4) - 2));
		it.row = 5'(clamp_coord(focus_row + $urandom_range(0, 4) - 2));
		it.layer = 2'(focus_layer);
		roll = $urandom_range(0, 9);
		if (roll < 8)
			it.tile_value = palette[$urandom_range(0, 1)];
		else if (roll < 9)
			it.tile_value = '0;
		else
			it.tile_value = tba_pkg::CODE_W'($urandom_range(0, 255));
		return it;
	endfunction

	initial begin
		stim_row_t        row;
		int               burst_left;
		int               idle;
		int               taken;
		int               since_focus;
		tba_pkg::result_t none;
		none = '0;
		foreach (tile_mirror[i])
			tile_mirror[i] = '0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cur_row.it = '0;
		cur_row.n_typed = EXPECT_PREDICTED;
		cur_row.typed = '0;

		// corner of map 0, out-of-range and unused transactions
		add_row(tba_pkg::OP_CLASSIFY, 4'd0, 5'd0, 5'd0, 2'd0, 8'h00, 0, none);
		add_row(tba_pkg::OP_WRITE, 4'd0, 5'd0, 5'd0, 2'd0, 8'hFF, 0, none);
		add_row(tba_pkg::OP_CLASSIFY, 4'd0, 5'd0, 5'd0, 2'd0, 8'h00, 1,
			tba_pkg::result_t'{4'd0, 5'd0, 5'd0, 2'd0, SHAPE_ALONE, 1'b1});
		add_row(tba_pkg::OP_PLACE, 4'd0, 5'd1, 5'd0, 2'd0, 8'hFF, EXPECT_PREDICTED, none);
		add_row(OP_UNUSED, 4'd0, 5'd0, 5'd0, 2'd0, 8'h00, 0, none);
		add_row(tba_pkg::OP_PLACE, 4'd15, 5'd31, 5'd31, 2'd3, 8'h55, 0, none);
		add_row(tba_pkg::OP_WRITE, 4'd9, 5'd1, 5'd0, 2'd0, 8'h00, 0, none);
		add_row(tba_pkg::OP_CLASSIFY, 4'd0, 5'd1, 5'd0, 2'd0, 8'h00, EXPECT_PREDICTED, none);
		// solid 3x3 block on the top map and layer, centre placed last
		for (int dy = -1; dy <= 1; dy++)
			for (int dx = -1; dx <= 1; dx++)
				if (dx != 0 || dy != 0)
					add_row(tba_pkg::OP_WRITE, 4'd8, 5'(15 + dx), 5'(15 + dy), 2'd3, 8'hAA,
						0, none);
		add_row(tba_pkg::OP_PLACE, 4'd8, 5'd15, 5'd15, 2'd3, 8'hAA, EXPECT_PREDICTED, none);
		add_row(tba_pkg::OP_CLASSIFY, 4'd8, 5'd15, 5'd15, 2'd3, 8'h00, 1,
			tba_pkg::result_t'{4'd8, 5'd15, 5'd15, 2'd3, SHAPE_FULL, 1'b1});
		add_row(tba_pkg::OP_PLACE, 4'd8, 5'd31, 5'd31, 2'd3, 8'h01, 1,
			tba_pkg::result_t'{4'd8, 5'd31, 5'd31, 2'd3, SHAPE_ALONE, 1'b1});
		// clearing the centre reports only the ring
		add_row(tba_pkg::OP_PLACE, 4'd8, 5'd15, 5'd15, 2'd3, 8'h00, EXPECT_PREDICTED, none);
		add_row(tba_pkg::OP_CLASSIFY, 4'd8, 5'd15, 5'd15, 2'd3, 8'h00, 0, none);
		add_row(tba_pkg::OP_PLACE, 4'd8, 5'd31, 5'd0, 2'd3, 8'h80, 1,
			tba_pkg::result_t'{4'd8, 5'd31, 5'd0, 2'd3, SHAPE_ALONE, 1'b1});
		add_row(tba_pkg::OP_PLACE, 4'd0, 5'd0, 5'd31, 2'd0, 8'h55, 1,
			tba_pkg::result_t'{4'd0, 5'd0, 5'd31, 2'd0, SHAPE_ALONE, 1'b1});
		add_row(tba_pkg::OP_PLACE, 4'd0, 5'd0, 5'd1, 2'd0, 8'hFF, EXPECT_PREDICTED, none);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		burst_left = 0;
		foreach (directed_rows[i]) begin
			idle = 0;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 6);
				idle = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 15);
			end
			burst_left--;
			send_row(directed_rows[i], idle);
		end

		taken = 0;
		since_focus = 0;
		new_focus();
		row.n_typed = EXPECT_PREDICTED;
		row.typed = '0;
		while (taken < RANDOM_ITEMS) begin
			if (since_focus >= $urandom_range(8, 20)) begin
				new_focus();
				since_focus = 0;
			end
			row.it = random_item();
			idle = 0;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 10);
				idle = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
			end
			burst_left--;
			send_row(row, idle);
			since_focus++;
			taken++;
		end
		start <= 1'b0;

		@(posedge clk);
		while (shapes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (shapes_due.size() != 0)
			flag_mismatch("results still pending", shapes_due.size(), 0);

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/tba_pkg.sv
rtl/tilemap_blob_autotile.sv
tb/testbench.sv
